@@ rtl/core/mrpt_pkg.sv @@
package mrpt_pkg;

  localparam int MaxBases = 12;
  localparam int BaseWidth = 6;

  typedef logic [BaseWidth-1:0] base_t;

  function automatic base_t base_at(input logic [3:0] k);
    base_t b;
    case (k)
      4'd0: b = 6'd2;
      4'd1: b = 6'd3;
      4'd2: b = 6'd5;
      4'd3: b = 6'd7;
      4'd4: b = 6'd11;
      4'd5: b = 6'd13;
      4'd6: b = 6'd17;
      4'd7: b = 6'd19;
      4'd8: b = 6'd23;
      4'd9: b = 6'd29;
      4'd10: b = 6'd31;
      4'd11: b = 6'd37;
      default: b = 6'd2;
    endcase
    return b;
  endfunction

  typedef struct packed {
    logic start;
    logic busy;
  } mul_ctl_t;

endpackage

@@ rtl/core/mrpt_mulmod.sv @@
module mrpt_mulmod #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         busy,
  output logic [W-1:0] r
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] r_r, r_nxt, a_r, b_r, m_r;
  logic [CW-1:0] cnt_r;
  logic busy_r;
  logic [W-1:0] d, room_a;

  function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] mm);
    logic [W-1:0] room;
    room = mm - y;
    return (x >= room) ? x - room : x + y;
  endfunction

  always_comb begin
    d = addm(r_r, r_r, m_r);
    room_a = addm(d, a_r, m_r);
    r_nxt = b_r[W-1] ? room_a : d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= CW'(W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r_r <= '0;
      a_r <= a;
      b_r <= b;
      m_r <= m;
    end else if (busy_r) begin
      r_r <= r_nxt;
      b_r <= {b_r[W-2:0], 1'b0};
    end
  end

  assign busy = busy_r;
  assign r = r_r;
endmodule

@@ rtl/core/miller_rabin_prime_test.sv @@
// Channel | Ports                           | Dir
// input   | in_valid, in_ready, in_candidate| in
// result  | out_valid, out_ready, out_is_prime | out
// One candidate at a time; the serial modular multiplier (one bit of the
// multiplier per cycle) sets the rate.
// Roughly BASE_COUNT * 2 * NUMBER_WIDTH products in the worst case; trivial
// candidates (below 4, or even) finish without a product.
// Reset (rst_n low, synchronous) returns to idle and drops any pending result.
// A result held by out_ready low blocks the next request.
module miller_rabin_prime_test #(
  parameter int NUMBER_WIDTH = 64,
  parameter int BASE_COUNT = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_candidate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_prime
);
  import mrpt_pkg::*;

  localparam int W = NUMBER_WIDTH;
  localparam int WW = $clog2(W + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SPLIT = 9'b000000010,
    S_BASE  = 9'b000000100,
    S_PMUL  = 9'b000001000,
    S_PSQ   = 9'b000010000,
    S_PNEXT = 9'b000100000,
    S_CHK   = 9'b001000000,
    S_SQ    = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r;
  logic [W-1:0] n_r, z_r, e_r, res_r, b_r, x_r;
  logic [WW-1:0] w_r, i_r;
  logic [3:0] k_r;
  logic prime_r, wait_r;
  logic mbusy;
  logic start_r;
  mul_ctl_t mc;
  logic [W-1:0] ma_r, mb_r, mr;
  logic [W-1:0] nm1;
  logic [W-1:0] base_w;

  assign nm1 = n_r - 1'b1;
  assign base_w = W'(base_at(k_r));
  assign mc.busy = 1'b0 | mbusy;
  assign mc.start = start_r;

  mrpt_mulmod #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mc.start), .a(ma_r), .b(mb_r), .m(n_r),
    .busy(mbusy), .r(mr)
  );

  assign in_ready = (state_r == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      start_r <= 1'b0;
      wait_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          n_r <= in_candidate[W-1:0];
          state_r <= S_SPLIT;
          z_r <= in_candidate[W-1:0] - 1'b1;
          w_r <= '0;
          k_r <= '0;
        end
        S_SPLIT: begin
          if (n_r < W'(2)) begin
            prime_r <= 1'b0; state_r <= S_DONE;
          end else if (n_r == W'(2) || n_r == W'(3)) begin
            prime_r <= 1'b1; state_r <= S_DONE;
          end else if (!n_r[0]) begin
            prime_r <= 1'b0; state_r <= S_DONE;
          end else if (!z_r[0]) begin
            z_r <= z_r >> 1;
            w_r <= w_r + 1'b1;
          end else begin
            state_r <= S_BASE;
          end
        end
        S_BASE: begin
          if (k_r == 4'(BASE_COUNT) || k_r == 4'(MaxBases) || base_w >= n_r) begin
            prime_r <= 1'b1; state_r <= S_DONE;
          end else begin
            res_r <= W'(1);
            b_r <= base_w;
            e_r <= z_r;
            state_r <= S_PNEXT;
          end
        end
        S_PNEXT: begin
          if (e_r == '0) begin
            x_r <= res_r; i_r <= WW'(1); state_r <= S_CHK;
          end else if (e_r[0]) begin
            ma_r <= res_r; mb_r <= b_r; start_r <= 1'b1; wait_r <= 1'b1;
            state_r <= S_PMUL;
          end else begin
            ma_r <= b_r; mb_r <= b_r; start_r <= 1'b1; wait_r <= 1'b1;
            state_r <= S_PSQ;
          end
        end
        S_PMUL: if (!start_r && !mbusy) begin
          res_r <= mr;
          ma_r <= b_r; mb_r <= b_r; start_r <= 1'b1;
          state_r <= S_PSQ;
        end
        S_PSQ: if (!start_r && !mbusy) begin
          b_r <= mr; e_r <= e_r >> 1; wait_r <= 1'b0;
          state_r <= S_PNEXT;
        end
        S_CHK: begin
          if (i_r == WW'(1) && (x_r == W'(1) || x_r == nm1)) begin
            k_r <= k_r + 1'b1; state_r <= S_BASE;
          end else if (i_r != WW'(1) && x_r == nm1) begin
            k_r <= k_r + 1'b1; state_r <= S_BASE;
          end else if ((i_r != WW'(1) && x_r == W'(1)) || i_r >= w_r) begin
            prime_r <= 1'b0; state_r <= S_DONE;
          end else begin
            ma_r <= x_r; mb_r <= x_r; start_r <= 1'b1;
            state_r <= S_SQ;
          end
        end
        S_SQ: if (!start_r && !mbusy) begin
          x_r <= mr; i_r <= i_r + 1'b1; state_r <= S_CHK;
        end
        S_DONE: begin
          out_valid <= 1'b1; out_is_prime <= prime_r; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (mc.start) |=> mbusy) else $error("multiplier did not start");
  assert property (@(posedge clk) disable iff (!rst_n)
    (mc.busy && !wait_r) |-> (state_r == S_SQ)) else $error("stray multiply");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid) else $error("result lost");
endmodule

@@ dv/tb_miller_rabin_prime_test.sv @@
module tb_miller_rabin_prime_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_candidate;
  logic        out_valid;
  logic        out_ready;
  logic        out_is_prime;

  int unsigned requests_taken;
  int unsigned hold_cycles;
  bit          quiet_out;

  miller_rabin_prime_test dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_candidate(in_candidate),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_is_prime(out_is_prime)
  );

  class primality_board;
    bit          pending_verdicts[$];
    logic [63:0] pending_numbers[$];
    int unsigned mismatches;
    int unsigned verdicts_seen;
    int unsigned primes_seen;

    function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return 64'(prod % {64'd0, m});
    endfunction

    function automatic logic [63:0] pow_mod(logic [63:0] a, logic [63:0] e, logic [63:0] m);
      logic [63:0] acc;
      logic [63:0] sq;
      acc = 64'd1 % m;
      sq = a % m;
      while (e != 0) begin
        if (e[0]) acc = mul_mod(acc, sq, m);
        sq = mul_mod(sq, sq, m);
        e = e >> 1;
      end
      return acc;
    endfunction

    function automatic bit witness_passes(logic [63:0] n, logic [63:0] a, logic [63:0] z,
                                          int unsigned w);
      logic [63:0] x;
      x = pow_mod(a, z, n);
      if (x == 1 || x == n - 1) return 1'b1;
      for (int unsigned i = 1; i < w; i++) begin
        x = mul_mod(x, x, n);
        if (x == n - 1) return 1'b1;
        if (x == 1) return 1'b0;
      end
      return 1'b0;
    endfunction

    function automatic bit predict_prime(logic [63:0] n);
      logic [63:0] z;
      int unsigned w;
      logic [63:0] a;
      w = 0;
      if (n < 2) return 1'b0;
      if (n == 2 || n == 3) return 1'b1;
      if (!n[0]) return 1'b0;
      z = n - 1;
      while (!z[0]) begin
        z = z >> 1;
        w++;
      end
      for (int k = 0; k < 7; k++) begin
        a = 64'(mrpt_pkg::base_at(4'(k)));
        if (a >= n) break;
        if (!witness_passes(n, a, z, w)) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_request(logic [63:0] n);
      pending_verdicts.push_back(predict_prime(n));
      pending_numbers.push_back(n);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_verdict(bit got);
      bit want;
      logic [63:0] n;
      verdicts_seen++;
      if (got) primes_seen++;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("unexpected result is_prime=%0d", got));
      end else begin
        want = pending_verdicts.pop_front();
        n = pending_numbers.pop_front();
        if (got !== want)
          report($sformatf("candidate %0d: is_prime=%0d, want %0d", n, got, want));
      end
    endtask
  endclass

  primality_board board;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      board.note_request(in_candidate);
      requests_taken <= requests_taken + 1;
    end
    if (rst_n && out_valid && out_ready) board.check_verdict(out_is_prime);
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else if (quiet_out) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 21);
      end
    end
  end

  task send_candidate(logic [63:0] n, bit keep_busy);
    int unsigned taken_before;
    taken_before = requests_taken;
    in_valid <= 1'b1;
    in_candidate <= n;
    do @(negedge clk); while (requests_taken == taken_before);
    if (!keep_busy && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      in_candidate <= {$urandom, $urandom};
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  function automatic logic [63:0] random_candidate();
    int unsigned pick;
    int unsigned bits;
    logic [63:0] v;
    pick = $urandom_range(99);
    v = {$urandom, $urandom};
    if (pick < 70) begin
      bits = $urandom_range(3, 20);
      v = (v & ((64'd1 << bits) - 1)) | 64'd1;
    end else if (pick < 80) begin
      v[0] = 1'b0;
    end else if (pick < 90) begin
      v = 64'($urandom_range(0, 40));
    end else begin
      v[0] = 1'b1;
    end
    return v;
  endfunction

  logic [63:0] directed[$] = '{
    64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd7, 64'd9, 64'd11, 64'd13,
    64'd17, 64'd19, 64'd25, 64'd561, 64'd2047, 64'd1373653, 64'd3215031751,
    64'h1FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF,
    64'h8000_0000_0000_0000, 64'd3825123056546413051, 64'hAAAA_AAAA_5555_5555
  };

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_candidate = '0;
    requests_taken = 0;
    hold_cycles = 0;
    quiet_out = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_candidate(directed[i], 1'b0);

    hold_cycles <= 70000;
    for (int i = 0; i < 100; i++) begin
      quiet_out <= (i >= 40 && i < 55);
      send_candidate(random_candidate(), i >= 40 && i < 55);
    end
    in_valid <= 1'b0;
    quiet_out <= 1'b0;

    while (board.pending_verdicts.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("Checked %0d verdicts (%0d prime) over small, even, wide and pseudoprime inputs.",
             board.verdicts_seen, board.primes_seen);
    $display("Output stalled for a long stretch while requests kept arriving.");
    if (board.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("Timeout with %0d results outstanding", board.pending_verdicts.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/mrpt_pkg.sv
rtl/core/mrpt_mulmod.sv
rtl/core/miller_rabin_prime_test.sv
dv/tb_miller_rabin_prime_test.sv
